// ===== sv/smas_pkg.sv =====
// Shared constants, types and sequencer states for the signed moving average block.
package smas_pkg;

   localparam int MAX_DEPTH   = 16;
   localparam int ADDR_W      = $clog2(MAX_DEPTH);
   localparam int COUNT_W     = $clog2(MAX_DEPTH + 1);
   localparam int SAMPLE_W    = 32;
   localparam int TIME_W      = 32;
   localparam int WLEN_W      = 5;
   localparam int SUM_W       = SAMPLE_W + ADDR_W;
   localparam int DIV_STEPS   = SUM_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [WLEN_W-1:0] WLEN_RESET  = WLEN_W'(16);
   localparam logic [TIME_W-1:0] TICKS_RESET = TIME_W'(15000);

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRESH_TICKS   = CSR_IDX_W'(1);

   localparam logic REQ_QUERY = 1'b0;
   localparam logic REQ_PUSH  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic               start;
      logic               neg;
      logic [SUM_W-1:0]   dividend;
      logic [COUNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                busy;
      logic [SAMPLE_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== sv/smas_intf.sv =====
// Valid/ready channel interfaces for request, response and register write beats.
interface smas_req_if;
   import smas_pkg::*;
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [SAMPLE_W-1:0] sample;
   logic [TIME_W-1:0]   now;
   modport source (output valid, output req_type, output sample, output now, input ready);
   modport sink   (input valid, input req_type, input sample, input now, output ready);
endinterface

interface smas_rsp_if;
   import smas_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] average;
   logic                fresh;
   modport source (output valid, output average, output fresh, input ready);
   modport sink   (input valid, input average, input fresh, output ready);
endinterface

interface smas_csr_if;
   import smas_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/smas_div.sv =====
// Bit-serial restoring divider with sign fixup for the running mean.
module smas_div (
   input  logic                 clock,
   input  logic                 reset,
   input  smas_pkg::div_req_type div_req,
   output smas_pkg::div_rsp_type div_rsp
);
   import smas_pkg::*;

   logic                busy_ff, busy_in;
   logic                neg_ff, neg_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [COUNT_W-1:0]  dvs_ff, dvs_in;
   logic [COUNT_W:0]    trial;
   logic                take;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign take  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         neg_in  = div_req.neg;
         step_in = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SUM_W-2:0], take};
         rem_in  = take ? COUNT_W'(trial - {1'b0, dvs_ff}) : trial[COUNT_W-1:0];
         step_in = step_ff + STEP_W'(1);
         busy_in = (step_ff != STEP_W'(DIV_STEPS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      neg_ff  <= neg_in;
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.quotient = neg_ff ? (SAMPLE_W'(0) - quo_ff[SAMPLE_W-1:0])
                                    : quo_ff[SAMPLE_W-1:0];

endmodule

// ===== sv/signed_moving_average_staleness_core.sv =====
// Top level: circular sample store, serial sum, shared divider and staleness flag.
// An item on an empty store skips the sum and the divider. A new item is taken only in idle,
// once the last result beat has been loaded; a result beat still waiting holds the next one.
// The sum reads one store entry per cycle; the divider retires one quotient bit per cycle.
// Reset clears the sequencer, fill count, write position, last update time and valid flags,
// and sets the window length and fresh ticks registers to their reset values.
module signed_moving_average_staleness_core (
   input logic       clock,
   input logic       reset,
   smas_req_if.sink   req_bus,
   smas_rsp_if.source rsp_bus,
   smas_csr_if.sink   csr_bus
);
   import smas_pkg::*;

   state_type            state_ff, state_in;
   logic [WLEN_W-1:0]    wlen_ff, wlen_in;
   logic [TIME_W-1:0]    ticks_ff, ticks_in;
   logic [ADDR_W-1:0]    wpos_ff, wpos_in;
   logic [COUNT_W-1:0]   fill_ff, fill_in;
   logic [TIME_W-1:0]    last_ff, last_in;
   logic                 fresh_ff, fresh_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic                 out_vld_ff, out_vld_in;
   logic [SAMPLE_W-1:0]  out_avg_ff, out_avg_in;
   logic                 out_fresh_ff, out_fresh_in;
   logic [SAMPLE_W-1:0]  rd_data_ff;
   logic [SAMPLE_W-1:0]  store_mem [MAX_DEPTH];

   logic                 req_acc, csr_acc, push, sum_done, slot_free;
   logic                 ready_out, start_div, load_out;
   logic [COUNT_W-1:0]   eff_len, pos, pos_next, fill_new;
   logic [TIME_W-1:0]    last_new, deadline;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   assign req_acc   = req_bus.valid && ready_out;
   assign csr_acc   = csr_bus.valid;
   assign push      = req_acc && (req_bus.req_type == REQ_PUSH);
   assign sum_done  = (cnt_ff == fill_ff) && !rd_vld_ff;
   assign slot_free = !out_vld_ff || rsp_bus.ready;

   always_comb begin
      if (wlen_ff == '0) begin
         eff_len = COUNT_W'(1);
      end else if ({{(COUNT_W+1-WLEN_W){1'b0}}, wlen_ff} > (COUNT_W+1)'(MAX_DEPTH)) begin
         eff_len = COUNT_W'(MAX_DEPTH);
      end else begin
         eff_len = COUNT_W'(wlen_ff);
      end
   end

   assign pos      = ({1'b0, wpos_ff} >= eff_len) ? '0 : {1'b0, wpos_ff};
   assign pos_next = pos + COUNT_W'(1);
   assign fill_new = (req_bus.req_type == REQ_PUSH) ?
                     ((fill_ff < eff_len) ? fill_ff + COUNT_W'(1) : eff_len) : fill_ff;
   assign last_new = (req_bus.req_type == REQ_PUSH) ? req_bus.now : last_ff;
   assign deadline = last_new + ticks_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = (fill_new == '0) ? ST_FIN : ST_SUM;
            end
         end
         ST_SUM: begin
            if (sum_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!div_rsp.busy) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ready_out = 1'b0;
      start_div = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: ready_out = 1'b1;
         ST_SUM:  start_div = sum_done;
         ST_DIV:  ;
         ST_FIN:  load_out  = slot_free;
         default: ;
      endcase
   end

   assign div_req.start    = start_div;
   assign div_req.neg      = acc_ff[SUM_W-1];
   assign div_req.dividend = acc_ff[SUM_W-1] ? SUM_W'(SUM_W'(0) - acc_ff) : SUM_W'(acc_ff);
   assign div_req.divisor  = fill_ff;

   smas_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      wlen_in      = wlen_ff;
      ticks_in     = ticks_ff;
      wpos_in      = wpos_ff;
      fill_in      = fill_ff;
      last_in      = last_ff;
      fresh_in     = fresh_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = 1'b0;
      acc_in       = acc_ff;
      out_vld_in   = out_vld_ff;
      out_avg_in   = out_avg_ff;
      out_fresh_in = out_fresh_ff;

      if (csr_acc) begin
         case (csr_bus.index)
            CSR_WINDOW_LENGTH: begin
               wlen_in = csr_bus.data[WLEN_W-1:0];
               wpos_in = '0;
               fill_in = '0;
            end
            CSR_FRESH_TICKS: ticks_in = csr_bus.data[TIME_W-1:0];
            default: ;
         endcase
      end

      if (req_acc) begin
         fill_in  = fill_new;
         last_in  = last_new;
         fresh_in = (fill_new != '0) && (req_bus.now < deadline);
         cnt_in   = '0;
         acc_in   = '0;
         if (push) begin
            wpos_in = (pos_next >= eff_len) ? '0 : pos_next[ADDR_W-1:0];
         end
      end

      if (state_ff == ST_SUM) begin
         if (cnt_ff < fill_ff) begin
            cnt_in    = cnt_ff + COUNT_W'(1);
            rd_vld_in = 1'b1;
         end
         if (rd_vld_ff) begin
            acc_in = acc_ff + SUM_W'(signed'(rd_data_ff));
         end
      end

      if (rsp_bus.valid && rsp_bus.ready) begin
         out_vld_in = 1'b0;
      end
      if (load_out) begin
         out_vld_in   = 1'b1;
         out_avg_in   = (fill_ff == '0) ? '0 : div_rsp.quotient;
         out_fresh_in = fresh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wlen_ff    <= WLEN_RESET;
         ticks_ff   <= TICKS_RESET;
         wpos_ff    <= '0;
         fill_ff    <= '0;
         last_ff    <= '0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wlen_ff    <= wlen_in;
         ticks_ff   <= ticks_in;
         wpos_ff    <= wpos_in;
         fill_ff    <= fill_in;
         last_ff    <= last_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
      fresh_ff     <= fresh_in;
      cnt_ff       <= cnt_in;
      acc_ff       <= acc_in;
      out_avg_ff   <= out_avg_in;
      out_fresh_ff <= out_fresh_in;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_mem[pos[ADDR_W-1:0]] <= req_bus.sample;
      end
      rd_data_ff <= store_mem[cnt_ff[ADDR_W-1:0]];
   end

   assign req_bus.ready   = ready_out;
   assign csr_bus.ready   = 1'b1;
   assign rsp_bus.valid   = out_vld_ff;
   assign rsp_bus.average = out_avg_ff;
   assign rsp_bus.fresh   = out_fresh_ff;

endmodule

// ===== test/tb.sv =====
// Self-checking bench for the signed moving average core: directed table, then random phases.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import smas_pkg::*;

   localparam int STALL_LIMIT     = 2000;
   localparam int TAIL_CYCLES     = 64;
   localparam int RANDOM_PHASES   = 24;
   localparam int ITEMS_PER_PHASE = 64;
   localparam int PLAN_ROWS       = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(3);

   typedef enum logic { ROW_ITEM, ROW_CSR } row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic                  req_type;
      logic [SAMPLE_W-1:0]   value;
      logic [TIME_W-1:0]     now;
      bit                    typed;
      logic [SAMPLE_W-1:0]   average;
      logic                  fresh;
   } plan_row_type;

   typedef struct {
      logic [SAMPLE_W-1:0] average;
      logic                fresh;
   } mean_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic drain_ready = 1'b0;
   bit   steady_run = 1'b0;

   smas_req_if req_if ();
   smas_rsp_if rsp_if ();
   smas_csr_if csr_if ();

   assign rsp_if.ready = drain_ready;

   signed_moving_average_staleness_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // filter state kept by the bench
   logic [WLEN_W-1:0]          win_len     = WLEN_RESET;
   logic [TIME_W-1:0]          fresh_ticks = TICKS_RESET;
   logic signed [SAMPLE_W-1:0] history [MAX_DEPTH];
   int unsigned                slot        = 0;
   int unsigned                filled      = 0;
   logic [TIME_W-1:0]          last_push   = '0;

   mean_result_type pending_results [$];
   int errors          = 0;
   int results_checked = 0;
   int items_sent      = 0;
   int pushes_sent     = 0;
   int settings_written = 0;
   int idle_cycles     = 0;

   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_QUERY, 32'h0000_0000, 32'd0,         1, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_PUSH,  32'h7FFF_FFFF, 32'd100,       1, 32'h7FFF_FFFF, 1},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_PUSH,  32'h7FFF_FFFF, 32'd200,       1, 32'h7FFF_FFFF, 1},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_PUSH,  32'h8000_0000, 32'd300,       0, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_QUERY, 32'h1234_5678, 32'd15299,     0, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_QUERY, 32'hFFFF_FFFF, 32'd15300,     0, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_QUERY, 32'h0000_0000, 32'hFFFF_FFFF, 0, 32'h0000_0000, 0},
      '{ROW_CSR,  CSR_WINDOW_LENGTH, REQ_QUERY, 32'd1,         32'd0,         0, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_QUERY, 32'h0000_0000, 32'd0,         1, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_PUSH,  32'h8000_0000, 32'd5,         1, 32'h8000_0000, 1},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_PUSH,  32'hFFFF_FFFF, 32'd6,         1, 32'hFFFF_FFFF, 1},
      '{ROW_CSR,  CSR_FRESH_TICKS,   REQ_QUERY, 32'd0,         32'd0,         0, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_PUSH,  32'd7,         32'd10,        1, 32'd7,         0},
      '{ROW_CSR,  CSR_FRESH_TICKS,   REQ_QUERY, 32'hFFFF_FFFF, 32'd0,         0, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_QUERY, 32'h0000_0000, 32'd8,         1, 32'd7,         1},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_QUERY, 32'h0000_0000, 32'd9,         1, 32'd7,         0},
      '{ROW_CSR,  CSR_WINDOW_LENGTH, REQ_QUERY, 32'hFFFF_FFE0, 32'd0,         0, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_PUSH,  32'd5,         32'd100,       1, 32'd5,         0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_PUSH,  32'd9,         32'd101,       1, 32'd9,         0},
      '{ROW_CSR,  CSR_WINDOW_LENGTH, REQ_QUERY, 32'h0000_001F, 32'd0,         0, 32'h0000_0000, 0},
      '{ROW_CSR,  CSR_FRESH_TICKS,   REQ_QUERY, 32'd1000,      32'd0,         0, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_PUSH,  32'hFFFF_FFFD, 32'hFFFF_FF00, 0, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_QUERY, 32'h0000_0000, 32'd100,       0, 32'h0000_0000, 0},
      '{ROW_CSR,  CSR_WINDOW_LENGTH, REQ_QUERY, 32'd2,         32'd0,         0, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_PUSH,  32'hFFFF_FFF9, 32'd1,         0, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_PUSH,  32'd4,         32'd2,         0, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_PUSH,  32'd6,         32'd3,         0, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_PUSH,  32'h8000_0000, 32'd4,         0, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_PUSH,  32'h8000_0000, 32'd5,         1, 32'h8000_0000, 1},
      '{ROW_CSR,  CSR_SPARE_LO,      REQ_QUERY, 32'd1,         32'd0,         0, 32'h0000_0000, 0},
      '{ROW_CSR,  CSR_SPARE_HI,      REQ_QUERY, 32'd0,         32'd0,         0, 32'h0000_0000, 0},
      '{ROW_ITEM, CSR_WINDOW_LENGTH, REQ_QUERY, 32'h0000_0000, 32'd6,         1, 32'h8000_0000, 1}
   };

   function automatic void advance_filter(input logic kind, input logic signed [SAMPLE_W-1:0] value,
                                          input logic [TIME_W-1:0] at,
                                          output logic [SAMPLE_W-1:0] average,
                                          output logic fresh);
      int unsigned       span;
      longint            total;
      logic [TIME_W-1:0] deadline;
      span = (win_len == 0) ? 1 : ((win_len > MAX_DEPTH) ? MAX_DEPTH : win_len);
      if (kind == REQ_PUSH) begin
         if (slot >= span) slot = 0;
         history[slot] = value;
         slot = (slot + 1 >= span) ? 0 : slot + 1;
         if (filled < span) filled++;
         last_push = at;
      end
      total = 0;
      for (int unsigned i = 0; i < filled; i++) total += history[i];
      average  = (filled == 0) ? '0 : SAMPLE_W'(total / longint'(filled));
      deadline = last_push + fresh_ticks;
      fresh    = (filled != 0) && (at < deadline);
   endfunction

   task automatic drive_item(input logic kind, input logic [SAMPLE_W-1:0] value,
                             input logic [TIME_W-1:0] at, input bit typed,
                             input logic [SAMPLE_W-1:0] typed_average, input logic typed_fresh);
      mean_result_type predicted;
      csr_if.valid <= 1'b0;
      while (!steady_run && $urandom_range(99) < 25) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.req_type <= kind;
      req_if.sample   <= value;
      req_if.now      <= at;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      advance_filter(kind, value, at, predicted.average, predicted.fresh);
      if (typed) begin
         predicted.average = typed_average;
         predicted.fresh   = typed_fresh;
      end
      pending_results.push_back(predicted);
      items_sent++;
      if (kind == REQ_PUSH) pushes_sent++;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (index)
         CSR_WINDOW_LENGTH: begin
            win_len = value[WLEN_W-1:0];
            slot    = 0;
            filled  = 0;
         end
         CSR_FRESH_TICKS: fresh_ticks = value;
         default: ;
      endcase
      settings_written++;
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) drain_ready <= steady_run || ($urandom_range(99) >= 25);

   always @(posedge clock) begin : check_results
      mean_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected beat, average %h fresh %b", $time,
                     rsp_if.average, rsp_if.fresh);
            errors++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_if.average !== want.average) begin
               $display("%0t: average mismatch, expected %h, actual %h", $time,
                        want.average, rsp_if.average);
               errors++;
            end
            if (rsp_if.fresh !== want.fresh) begin
               $display("%0t: fresh mismatch, expected %b, actual %b", $time,
                        want.fresh, rsp_if.fresh);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [WLEN_W-1:0]     wlen_pick;
      logic [CSR_DATA_W-1:0] word;
      logic [TIME_W-1:0]     cursor;
      logic [SAMPLE_W-1:0]   value;
      logic                  kind;
      req_if.valid    <= 1'b0;
      req_if.req_type <= REQ_QUERY;
      req_if.sample   <= '0;
      req_if.now      <= '0;
      csr_if.valid    <= 1'b0;
      csr_if.index    <= CSR_WINDOW_LENGTH;
      csr_if.data     <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            csr_write(plan[i].index, plan[i].value);
         end else begin
            drive_item(plan[i].req_type, plan[i].value, plan[i].now, plan[i].typed,
                       plan[i].average, plan[i].fresh);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         steady_run <= (phase >= 10 && phase < 13);
         settle();
         case (phase % 6)
            0, 5: wlen_pick = WLEN_W'($urandom_range(16, 1));
            1: wlen_pick = WLEN_W'(16);
            2: wlen_pick = WLEN_W'(1);
            3: wlen_pick = WLEN_W'($urandom_range(5, 2));
            default: wlen_pick = ($urandom_range(1) == 0) ? '0 : WLEN_W'($urandom_range(31, 17));
         endcase
         if (phase < 6 || $urandom_range(99) < 80) begin
            word = $urandom();
            word[WLEN_W-1:0] = wlen_pick;
            csr_write(CSR_WINDOW_LENGTH, word);
         end
         if ($urandom_range(99) < 70) begin
            case ($urandom_range(7))
               0: word = '0;
               1: word = '1;
               2: word = $urandom();
               3: word = 32'hFFFF_FFFF - $urandom_range(500);
               default: word = $urandom_range(2000, 1);
            endcase
            csr_write(CSR_FRESH_TICKS, word);
         end
         if ($urandom_range(3) == 0)
            csr_write(($urandom_range(1) == 0) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom());
         cursor = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(3000) : $urandom();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            kind = ($urandom_range(99) < 70) ? REQ_PUSH : REQ_QUERY;
            case ($urandom_range(19))
               0, 1:    value = 32'h7FFF_FFFF;
               2, 3:    value = 32'h8000_0000;
               4:       value = '0;
               5:       value = '1;
               6, 7, 8: value = $urandom_range(200) - 100;
               default: value = $urandom();
            endcase
            case ($urandom_range(19))
               0:       cursor = $urandom();
               1:       ;
               2, 3:    cursor = cursor + $urandom_range(3000);
               default: cursor = cursor + $urandom_range(400);
            endcase
            drive_item(kind, value, cursor, 1'b0, '0, 1'b0);
         end
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d items (%0d pushes, %0d queries) across %0d register writes;",
               items_sent, pushes_sent, items_sent - pushes_sent, settings_written);
      $display("checked %0d results, %0d mismatches.", results_checked, errors);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
